// File: rtl/core/coam_pkg.sv
// Shared constants, types and arithmetic helpers for the camera orientation core.
`timescale 1ns / 1ps
package coam_pkg;

	localparam int CORDIC_ITERATIONS = 14;
	localparam int POSITION_WIDTH    = 32;

	localparam int CORD_STEPS = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
	localparam int CIT_W      = (CORD_STEPS > 1) ? $clog2(CORD_STEPS) : 1;

	localparam int FULL_TURN    = 23040;
	localparam int HALF_TURN    = 11520;
	localparam int QUARTER_TURN = 5760;
	localparam int UNIT14       = 16384;
	localparam int ONE_OVER_K   = 652032874;

	localparam int WRAP_STEPS  = 7;
	localparam int WRAP_OFFSET = FULL_TURN * (2 ** WRAP_STEPS);

	localparam logic [1:0] REG_LOOK_SENS   = 2'd0;
	localparam logic [1:0] REG_MOVE_SPEED  = 2'd1;
	localparam logic [1:0] REG_PITCH_LIMIT = 2'd2;

	localparam logic CMD_LOOK = 1'b0;

	localparam logic SEL_YAW   = 1'b0;
	localparam logic SEL_PITCH = 1'b1;

	localparam logic [2:0] KEY_FWD   = 3'd0;
	localparam logic [2:0] KEY_BACK  = 3'd1;
	localparam logic [2:0] KEY_LEFT  = 3'd2;
	localparam logic [2:0] KEY_RIGHT = 3'd3;
	localparam logic [2:0] KEY_RISE  = 3'd4;
	localparam logic [2:0] KEY_SINK  = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_DX,
		ST_MUL_DY,
		ST_PITCH,
		ST_WRAP,
		ST_CINIT,
		ST_CITER,
		ST_CDONE,
		ST_VMUL,
		ST_VRND,
		ST_MUL_DIST,
		ST_DIST,
		ST_TMUL,
		ST_TADD,
		ST_DONE
	} state_t;

	function automatic logic signed [24:0] atan_deg16(input logic [4:0] idx);
		logic signed [24:0] r;
		case (idx)
			5'd0:  r = 25'sd2949120;
			5'd1:  r = 25'sd1740967;
			5'd2:  r = 25'sd919879;
			5'd3:  r = 25'sd466945;
			5'd4:  r = 25'sd234379;
			5'd5:  r = 25'sd117305;
			5'd6:  r = 25'sd58666;
			5'd7:  r = 25'sd29335;
			5'd8:  r = 25'sd14668;
			5'd9:  r = 25'sd7334;
			5'd10: r = 25'sd3667;
			5'd11: r = 25'sd1833;
			5'd12: r = 25'sd917;
			5'd13: r = 25'sd458;
			5'd14: r = 25'sd229;
			5'd15: r = 25'sd115;
			5'd16: r = 25'sd57;
			5'd17: r = 25'sd29;
			5'd18: r = 25'sd14;
			5'd19: r = 25'sd7;
			5'd20: r = 25'sd4;
			5'd21: r = 25'sd2;
			5'd22: r = 25'sd1;
			default: r = 25'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] to14(input logic signed [31:0] v);
		logic signed [32:0] t;
		logic signed [16:0] r;
		logic signed [15:0] o;
		t = 33'(v) + 33'sd32768;
		r = t[32:16];
		if (r > 17'sd16384)
			o = 16'sd16384;
		else if (r < -17'sd16384)
			o = -16'sd16384;
		else
			o = r[15:0];
		return o;
	endfunction

	function automatic logic signed [15:0] to14p(input logic signed [65:0] p);
		logic signed [65:0] t;
		logic signed [19:0] r;
		logic signed [15:0] o;
		t = p + 66'sd35184372088832;
		r = t[65:46];
		if (r > 20'sd16384)
			o = 16'sd16384;
		else if (r < -20'sd16384)
			o = -16'sd16384;
		else
			o = r[15:0];
		return o;
	endfunction

endpackage

// File: rtl/core/camera_orientation_and_motion_core.sv
// Camera orientation and motion core: shared multiplier and CORDIC under one sequencer.
//
//   channel  dir  beat contents (low bits first)
//   s_*      in   tuser: command; tdata: mouse_dx, mouse_dy, six keys, step_time
//   m_*      out  tdata: position x/y/z, front x/y/z, upvec x/y/z, yaw, pitch
//   cfg_*    in   register writes, no read-back
//
// Look beat: two sensitivity multiplies, pitch clamp, yaw wrap, CORDIC on yaw then on pitch, then
// four vector multiply/round pairs. Move beat: distance multiply, CORDIC on yaw, then a skip per
// released key and a multiply/add per axis per held key, on the shared 33 x 33 multiplier.
// Input is taken only when the sequencer is idle, in the cycle after each result is posted.
// The output register stalls the sequencer only if a previous result is still held.
// Reset is asynchronous and restores the power-on camera state and registers.
`timescale 1ns / 1ps
module camera_orientation_and_motion_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [55:0]  s_tdata,  // mouse_dx, mouse_dy, key_forward, key_back, key_left,
	                               // key_right, key_rise, key_sink, step_time, zero pad
	input  logic         s_tuser,  // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [223:0] m_tdata,  // position_x, position_y, position_z, front_x, front_y,
	                               // front_z, upvec_x, upvec_y, upvec_z, yaw_angle,
	                               // pitch_angle, zero pad
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import coam_pkg::*;

	localparam int PW    = POSITION_WIDTH;
	localparam int SUM_W = ((PW > 26) ? PW : 26) + 1;
	localparam int OW    = (PW > 32) ? PW : 32;
	localparam logic signed [SUM_W-1:0] PMAX = {{(SUM_W-PW+1){1'b0}}, {(PW-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] PMIN = {{(SUM_W-PW+1){1'b1}}, {(PW-1){1'b0}}};
	localparam logic signed [OW-1:0]    OMAX = {{(OW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [OW-1:0]    OMIN = {{(OW-31){1'b1}}, {31{1'b0}}};

	state_t state_q, state_d;

	logic [15:0] sens_q, speed_q;
	logic [12:0] plim_q;

	logic               cmd_q;
	logic signed [15:0] dx_q, dy_q;
	logic [5:0]         keys_q;
	logic [15:0]        step_q;

	logic signed [65:0] prod_q;
	logic [21:0]        wrap_q;
	logic [2:0]         wcnt_q;

	logic [14:0]        yaw_q;
	logic signed [13:0] pitch_q;
	logic signed [PW-1:0] pos_q [3];
	logic signed [15:0] front_q [3];
	logic signed [15:0] up_q [3];

	logic signed [31:0] crx_q, cry_q;
	logic signed [24:0] crz_q;
	logic [CIT_W-1:0]   iter_q;
	logic               flip_q, sel_q;
	logic signed [31:0] cosy_q, siny_q, cosp_q, sinp_q;
	logic [1:0]         vidx_q, comp_q;
	logic [2:0]         kidx_q;
	logic [31:0]        dist_q;

	logic         m_tvalid_q;
	logic [223:0] m_tdata_q;
	logic         out_free;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;

	logic [33:0]        dsum;
	logic signed [23:0] delta;
	logic signed [24:0] ysum, psum, lim, pnew;
	logic [21:0]        wrap_init, wsub;

	logic signed [15:0] ang, ang1, ang2;
	logic               fold_flip;
	logic signed [31:0] fx, fy;
	logic signed [24:0] at;

	logic signed [15:0] rx, rz, vec;
	logic [47:0]        tsum;
	logic signed [25:0] term;
	logic signed [SUM_W-1:0] psum2;
	logic signed [PW-1:0]    pos_new;
	logic signed [OW-1:0]    pext [3];
	logic [31:0]        pout [3];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign mul_p = mul_a * mul_b;

	// look arithmetic
	assign dsum  = prod_q[33:0] + 34'd512;
	assign delta = dsum[33:10];
	assign ysum  = 25'($signed({1'b0, yaw_q})) + 25'(delta);
	assign wrap_init = (ysum < 0) ? 22'(ysum + 25'(WRAP_OFFSET)) : 22'(ysum);
	assign wsub  = 22'(FULL_TURN) << wcnt_q;
	assign psum  = 25'(pitch_q) + 25'(delta);
	assign lim   = (plim_q > 13'(QUARTER_TURN)) ? 25'(QUARTER_TURN) : $signed({12'b0, plim_q});
	assign pnew  = (psum > lim) ? lim : ((psum < -lim) ? -lim : psum);

	// angle fold into -90..90 degrees
	always_comb begin
		ang = (sel_q == SEL_PITCH) ? 16'(pitch_q) : $signed({1'b0, yaw_q});
		ang1 = (ang >= 16'(HALF_TURN)) ? ang - 16'(FULL_TURN) : ang;
		fold_flip = 1'b0;
		ang2 = ang1;
		if (ang1 > 16'(QUARTER_TURN)) begin
			ang2 = ang1 - 16'(HALF_TURN);
			fold_flip = 1'b1;
		end else if (ang1 < -16'(QUARTER_TURN)) begin
			ang2 = ang1 + 16'(HALF_TURN);
			fold_flip = 1'b1;
		end
	end

	assign at = atan_deg16(5'(iter_q));
	assign fx = flip_q ? -crx_q : crx_q;
	assign fy = flip_q ? -cry_q : cry_q;

	// move arithmetic
	assign rx = to14(-siny_q);
	assign rz = to14(cosy_q);

	always_comb begin
		vec = '0;
		case (kidx_q)
			KEY_FWD:   vec = front_q[comp_q];
			KEY_BACK:  vec = -front_q[comp_q];
			KEY_LEFT:  vec = (comp_q == 2'd0) ? -rx : ((comp_q == 2'd2) ? -rz : 16'sd0);
			KEY_RIGHT: vec = (comp_q == 2'd0) ? rx : ((comp_q == 2'd2) ? rz : 16'sd0);
			KEY_RISE:  vec = (comp_q == 2'd1) ? 16'(UNIT14) : 16'sd0;
			KEY_SINK:  vec = (comp_q == 2'd1) ? -16'(UNIT14) : 16'sd0;
			default:   vec = '0;
		endcase
	end

	assign tsum  = prod_q[47:0] + 48'd2097152;
	assign term  = tsum[47:22];
	assign psum2 = SUM_W'(pos_q[comp_q]) + SUM_W'(term);
	assign pos_new = (psum2 > PMAX) ? PMAX[PW-1:0] :
	                 ((psum2 < PMIN) ? PMIN[PW-1:0] : psum2[PW-1:0]);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pext[i] = OW'(pos_q[i]);
			if (pext[i] > OMAX)
				pout[i] = OMAX[31:0];
			else if (pext[i] < OMIN)
				pout[i] = OMIN[31:0];
			else
				pout[i] = pext[i][31:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_DX: begin
				mul_a = 33'(dx_q);
				mul_b = $signed({17'b0, sens_q});
			end
			ST_MUL_DY: begin
				mul_a = 33'(dy_q);
				mul_b = $signed({17'b0, sens_q});
			end
			ST_VMUL: begin
				mul_a = (vidx_q[0]) ? 33'(siny_q) : 33'(cosy_q);
				mul_b = (vidx_q[1]) ? 33'(sinp_q) : 33'(cosp_q);
			end
			ST_MUL_DIST: begin
				mul_a = $signed({17'b0, speed_q});
				mul_b = $signed({17'b0, step_q});
			end
			ST_TMUL: begin
				mul_a = 33'(vec);
				mul_b = $signed({1'b0, dist_q});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = (s_tuser == CMD_LOOK) ? ST_MUL_DX : ST_MUL_DIST;
			ST_MUL_DX:   state_d = ST_MUL_DY;
			ST_MUL_DY:   state_d = ST_PITCH;
			ST_PITCH:    state_d = ST_WRAP;
			ST_WRAP:     if (wcnt_q == 3'd0) state_d = ST_CINIT;
			ST_CINIT:    state_d = ST_CITER;
			ST_CITER:    if (iter_q == CIT_W'(CORD_STEPS - 1)) state_d = ST_CDONE;
			ST_CDONE: begin
				if (sel_q == SEL_PITCH)
					state_d = ST_VMUL;
				else if (cmd_q == CMD_LOOK)
					state_d = ST_CINIT;
				else
					state_d = ST_TMUL;
			end
			ST_VMUL:     state_d = ST_VRND;
			ST_VRND:     state_d = (vidx_q == 2'd3) ? ST_DONE : ST_VMUL;
			ST_MUL_DIST: state_d = ST_DIST;
			ST_DIST:     state_d = ST_CINIT;
			ST_TMUL: begin
				if (keys_q[kidx_q])
					state_d = ST_TADD;
				else if (kidx_q == KEY_SINK)
					state_d = ST_DONE;
			end
			ST_TADD: begin
				if (comp_q == 2'd2 && kidx_q == KEY_SINK)
					state_d = ST_DONE;
				else
					state_d = ST_TMUL;
			end
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q  <= s_tuser;
			dx_q   <= s_tdata[15:0];
			dy_q   <= s_tdata[31:16];
			keys_q <= s_tdata[37:32];
			step_q <= s_tdata[53:38];
			sel_q  <= SEL_YAW;
		end
		case (state_q)
			ST_MUL_DX, ST_MUL_DY, ST_VMUL, ST_MUL_DIST, ST_TMUL: prod_q <= mul_p;
			default: ;
		endcase
		case (state_q)
			ST_MUL_DY: wrap_q <= wrap_init;
			ST_PITCH:  wcnt_q <= 3'(WRAP_STEPS - 1);
			ST_WRAP: begin
				if (wrap_q >= wsub)
					wrap_q <= wrap_q - wsub;
				wcnt_q <= wcnt_q - 3'd1;
			end
			ST_DIST: begin
				dist_q <= prod_q[31:0];
				kidx_q <= KEY_FWD;
				comp_q <= 2'd0;
			end
			ST_CINIT: begin
				crx_q  <= 32'(ONE_OVER_K);
				cry_q  <= '0;
				crz_q  <= 25'(ang2) <<< 10;
				flip_q <= fold_flip;
				iter_q <= '0;
			end
			ST_CITER: begin
				if (crz_q >= 0) begin
					crx_q <= crx_q - (cry_q >>> iter_q);
					cry_q <= cry_q + (crx_q >>> iter_q);
					crz_q <= crz_q - at;
				end else begin
					crx_q <= crx_q + (cry_q >>> iter_q);
					cry_q <= cry_q - (crx_q >>> iter_q);
					crz_q <= crz_q + at;
				end
				iter_q <= iter_q + CIT_W'(1);
			end
			ST_CDONE: begin
				if (sel_q == SEL_YAW) begin
					cosy_q <= fx;
					siny_q <= fy;
					sel_q  <= SEL_PITCH;
				end else begin
					cosp_q <= fx;
					sinp_q <= fy;
				end
				vidx_q <= 2'd0;
			end
			ST_VRND:   vidx_q <= vidx_q + 2'd1;
			ST_TMUL: begin
				if (!keys_q[kidx_q])
					kidx_q <= kidx_q + 3'd1;
			end
			ST_TADD: begin
				if (comp_q == 2'd2) begin
					comp_q <= 2'd0;
					kidx_q <= kidx_q + 3'd1;
				end else begin
					comp_q <= comp_q + 2'd1;
				end
			end
			default: ;
		endcase
		if (state_q == ST_DONE && out_free)
			m_tdata_q <= {3'b0, pitch_q, yaw_q, up_q[2], up_q[1], up_q[0],
			              front_q[2], front_q[1], front_q[0], pout[2], pout[1], pout[0]};
	end

	// camera state, registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q     <= 16'd6554;
			speed_q    <= 16'd1280;
			plim_q     <= 13'd5696;
			yaw_q      <= '0;
			pitch_q    <= '0;
			pos_q[0]   <= '0;
			pos_q[1]   <= '0;
			pos_q[2]   <= '0;
			front_q[0] <= 16'(UNIT14);
			front_q[1] <= '0;
			front_q[2] <= '0;
			up_q[0]    <= '0;
			up_q[1]    <= 16'(UNIT14);
			up_q[2]    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOOK_SENS:   sens_q  <= cfg_data;
					REG_MOVE_SPEED:  speed_q <= cfg_data;
					REG_PITCH_LIMIT: plim_q  <= cfg_data[12:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_PITCH: pitch_q <= pnew[13:0];
				ST_WRAP:  if (wcnt_q == 3'd0) yaw_q <= (wrap_q >= wsub) ? 15'(wrap_q - wsub) : wrap_q[14:0];
				ST_CDONE: begin
					if (sel_q == SEL_PITCH) begin
						front_q[1] <= to14(fy);
						up_q[1]    <= to14(fx);
					end
				end
				ST_VRND: begin
					case (vidx_q)
						2'd0: front_q[0] <= to14p(prod_q);
						2'd1: front_q[2] <= to14p(prod_q);
						2'd2: up_q[0]    <= to14p(-prod_q);
						default: up_q[2] <= to14p(-prod_q);
					endcase
				end
				ST_TADD:  pos_q[comp_q] <= pos_new;
				default: ;
			endcase
			if (state_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		yaw_q < 15'(FULL_TURN))
		else $error("yaw left its wrapped range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pitch_q <= 14'(QUARTER_TURN)) && (pitch_q >= -14'(QUARTER_TURN)))
		else $error("pitch beyond quarter turn");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while item in flight");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && s_tready))
		else $error("finished item not posted");

endmodule
